[hw/rtl/b2da_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, types and the shift-and-add-3 step of the decimal converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_W    = 32;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int STAGE_BITS = 8;
	localparam int NUM_STAGES = VALUE_W / STAGE_BITS;
	localparam int CHAR_W     = 6;
	localparam int POS_W      = 4;

	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
	localparam logic [POS_W-1:0]   LAST_POS     = 4'(NUM_DIGITS - 1);

	// working word of the conversion: decimal digits above, binary still to go below
	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} conv_t;

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

	// element 0 is the most significant digit
	typedef struct packed {
		digits_t          digits;
		logic [POS_W-1:0] start;
	} ser_item_t;

	function automatic conv_t dabble_shift(input conv_t c);
		conv_t r;
		r = c;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (r.bcd[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
				r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
			end
		end
		r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
		r.bin = {r.bin[VALUE_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

[hw/rtl/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned 32-bit binary to decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one 32-bit unsigned number per transaction in tdata.
//   m_axis returns its decimal digits as ASCII codes '0'..'9', one per
//   transaction, leading zeros dropped; tlast marks the units digit.
//   zero gives the single character '0' with tlast set.
// pipeline
//   four shift-and-add-3 stages of eight bits each, one digit-split stage and
//   the character register, which the number passes in that order; one
//   character follows per cycle after the first while m_axis_tready is high.
// throughput
//   the number rate is set by the single character output, one character
//   per digit (1 to 10); the pipeline takes a new number every cycle while
//   there is room, so up to six numbers are in flight.
// reset and stalls
//   arst_n empties every stage; no number or character is kept.
//   a low m_axis_tready holds the current character and the backlog fills
//   stage by stage until s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
	output logic        m_axis_tlast    // last_digit
);
	import b2da_pkg::*;

	conv_t     conv  [NUM_STAGES+1];
	logic      valid [NUM_STAGES+1];
	logic      ready [NUM_STAGES+1];
	ser_item_t lead_item;
	logic      lead_valid;
	logic      lead_ready;
	logic [CHAR_W-1:0] digit_char;

	assign conv[0].bcd   = '0;
	assign conv[0].bin   = s_axis_tdata;
	assign valid[0]      = s_axis_tvalid;
	assign s_axis_tready = ready[0];

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
		b2da_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[g]),
			.in_ready  (ready[g]),
			.in_data   (conv[g]),
			.out_valid (valid[g+1]),
			.out_ready (ready[g+1]),
			.out_data  (conv[g+1])
		);
	end

	b2da_lead u_lead (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid[NUM_STAGES]),
		.in_ready  (ready[NUM_STAGES]),
		.in_data   (conv[NUM_STAGES]),
		.out_valid (lead_valid),
		.out_ready (lead_ready),
		.out_data  (lead_item)
	);

	b2da_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lead_valid),
		.in_ready  (lead_ready),
		.in_data   (lead_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (digit_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, digit_char};

`ifndef SYNTHESIS
	// the input only backs up behind a character waiting at the output
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no character pending");

	// a run of digits is never broken by an idle cycle
	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a digit run");

	a_char_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'h3) && (m_axis_tdata[3:0] <= 4'd9))
		else $error("character outside 0..9");
`endif

endmodule

[hw/rtl/b2da_dabble_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_dabble_stage
// One pipeline stage of the converter: a fixed number of shift-and-add-3 steps.
// ----------------------------------------------------------------------------
module b2da_dabble_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  b2da_pkg::conv_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output b2da_pkg::conv_t out_data
);
	import b2da_pkg::*;

	conv_t stepped;
	conv_t conv_s1;
	logic  valid_s1;

	always_comb begin
		stepped = in_data;
		for (int i = 0; i < STAGE_BITS; i++) begin
			stepped = dabble_shift(stepped);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			conv_s1 <= stepped;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = conv_s1;

endmodule

[hw/rtl/b2da_lead.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_lead
// Splits the finished decimal word into digits and finds the first one shown.
// ----------------------------------------------------------------------------
module b2da_lead (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  b2da_pkg::conv_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output b2da_pkg::ser_item_t out_data
);
	import b2da_pkg::*;

	ser_item_t item;
	ser_item_t item_s5;
	logic      valid_s5;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			item.digits[i] = in_data.bcd[(NUM_DIGITS-1-i)*DIGIT_W +: DIGIT_W];
		end
		// all zeros still shows the units digit
		item.start = LAST_POS;
		for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
			if (item.digits[i] != '0) begin
				item.start = POS_W'(i);
			end
		end
	end

	assign in_ready = !valid_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (in_ready) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s5 <= item;
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = item_s5;

endmodule

[hw/rtl/b2da_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_serial
// Holds one converted number and sends its digits out as characters.
// ----------------------------------------------------------------------------
module b2da_serial (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  b2da_pkg::ser_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [b2da_pkg::CHAR_W-1:0] out_char,
	output logic                  out_last
);
	import b2da_pkg::*;

	digits_t          digits_q;
	logic [POS_W-1:0] pos_q;
	logic             busy_q;
	logic             at_last;
	logic             fire;

	assign at_last  = (pos_q == LAST_POS);
	assign fire     = busy_q && out_ready;
	// next number loads as the final character of this one leaves
	assign in_ready = !busy_q || (out_ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (in_ready && in_valid) begin
			busy_q <= 1'b1;
			pos_q  <= in_data.start;
		end else if (fire) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			digits_q <= in_data.digits;
		end
	end

	assign out_valid = busy_q;
	assign out_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_q[pos_q]};
	assign out_last  = at_last;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary to decimal ASCII converter.
// Numbers are pushed through the slave stream, and a model in the bench
// predicts the digit characters of every accepted number. Each character
// taken from the master stream is compared, in order, with that prediction.
// Runs cover corner numbers, random numbers weighted over all digit counts,
// a long output hold-off that backs the pipeline up, and a final stretch
// with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          CLK_HALF     = 5;
	localparam int          RESET_CYCLES = 12;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          HOLD_CYCLES  = 150;
	localparam int          MAX_REPORTS  = 100;
	localparam logic [31:0] TOP_PLACE    = 32'd1000000000;
	localparam logic [31:0] RADIX        = 32'd10;
	localparam logic [5:0]  CHAR_ZERO    = 6'd48;

	typedef struct packed {
		logic [5:0] code;
		logic       last;
	} dec_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;    // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [5:0] digit_char, [7:6] zero
	logic        m_axis_tlast;         // last_digit

	dec_char_t   expected_chars[$];
	int          errors = 0;
	int          values_taken = 0;
	int          chars_checked = 0;
	int          idle_cycles = 0;
	int          length_seen[1:10];
	logic        idle_en = 1'b1;
	logic        holding = 1'b0;
	int          rx_stall_left = 0;
	event        hold_ev;

	wire s_fire = s_axis_tvalid & s_axis_tready;
	wire m_fire = m_axis_tvalid & m_axis_tready;

	binary_to_decimal_ascii u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// decimal text of one number, leading zeros dropped, zero gives a single '0'
	function automatic void predict_decimal_text(input logic [31:0] number);
		logic [31:0] rest;
		logic [31:0] place;
		logic [31:0] digit;
		logic        started;
		int          count;
		dec_char_t   c;
		rest    = number;
		place   = TOP_PLACE;
		started = 1'b0;
		count   = 0;
		while (place != 0) begin
			digit = rest / place;
			rest  = rest % place;
			if (digit != 0) begin
				started = 1'b1;
			end
			if (started || place == 1) begin
				c.code = CHAR_ZERO + digit[5:0];
				c.last = (place == 1);
				expected_chars.push_back(c);
				count++;
			end
			place = place / RADIX;
		end
		length_seen[count]++;
	endfunction

	function automatic logic [31:0] decade_floor(input int digits);
		logic [31:0] p;
		p = 32'd1;
		for (int i = 1; i < digits; i++) begin
			p = p * RADIX;
		end
		return p;
	endfunction

	// input side: predict on accept; output side: compare with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_fire) begin
				predict_decimal_text(s_axis_tdata);
				values_taken++;
			end
			if (m_fire) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t: unexpected character, expected none, actual tdata 0x%02h last %0b",
							$time, m_axis_tdata, m_axis_tlast);
					end
				end else begin
					dec_char_t want;
					want = expected_chars.pop_front();
					if (m_axis_tdata[5:0] !== want.code) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: digit_char mismatch, expected %0d, actual %0d",
								$time, want.code, m_axis_tdata[5:0]);
						end
					end
					if (m_axis_tdata[7:6] !== 2'b00) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: tdata padding mismatch, expected 0, actual %0d",
								$time, m_axis_tdata[7:6]);
						end
					end
					if (m_axis_tlast !== want.last) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: last_digit mismatch, expected %0b, actual %0b",
								$time, want.last, m_axis_tlast);
						end
					end
				end
			end
		end
	end

	// long output hold-off, counted here so the sender keeps offering meanwhile
	initial begin
		forever begin
			@(hold_ev);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	// receiver: random stall bursts of random length
	always @(posedge clk) begin
		if (holding) begin
			m_axis_tready <= 1'b0;
		end else if (!idle_en) begin
			m_axis_tready <= 1'b1;
		end else if (rx_stall_left != 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left <= $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_fire || m_fire) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d characters still expected",
					$time, idle_cycles, expected_chars.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_value(input logic [31:0] number);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= number;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// random number, mostly spread evenly over the digit counts
	function automatic logic [31:0] random_value();
		int          pick;
		int          digits;
		logic [31:0] lo;
		logic [31:0] hi;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			digits = $urandom_range(1, 10);
			lo = (digits == 1) ? 32'd0 : decade_floor(digits);
			hi = (digits == 10) ? 32'hFFFF_FFFF : decade_floor(digits + 1) - 1;
			return $urandom_range(hi, lo);
		end else if (pick < 9) begin
			return $urandom;
		end
		return $urandom_range(20, 0);
	endfunction

	task automatic test_corner_values();
		logic [31:0] corners [22];
		corners = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
			32'd1000, 32'd10000, 32'd65535, 32'd65536, 32'd99999, 32'd100000,
			32'd1234567890, 32'd999999999, 32'd1000000000, 32'd1000000001,
			32'h8000_0000, 32'd4000000000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0};
		foreach (corners[i]) begin
			send_value(corners[i]);
		end
		stop_sending();
	endtask

	task automatic test_random_values(input int count);
		for (int i = 0; i < count; i++) begin
			send_value(random_value());
		end
		stop_sending();
	endtask

	task automatic test_output_hold();
		@(posedge clk);
		-> hold_ev;
		for (int i = 0; i < 25; i++) begin
			send_value(random_value());
		end
		stop_sending();
	endtask

	task automatic test_no_idling();
		@(posedge clk);
		idle_en <= 1'b0;
		for (int i = 0; i < 40; i++) begin
			send_value(random_value());
		end
		stop_sending();
	endtask

	initial begin
		int lengths_hit;
		foreach (length_seen[i]) begin
			length_seen[i] = 0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_corner_values();
		test_random_values(175);
		test_output_hold();
		test_no_idling();

		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		lengths_hit = 0;
		foreach (length_seen[i]) begin
			if (length_seen[i] != 0) begin
				lengths_hit++;
			end
		end
		$display("converted %0d numbers into %0d characters, %0d of 10 digit counts seen",
			values_taken, chars_checked, lengths_hit);
		$display("including a %0d-cycle output hold-off and a run with no idling",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_dabble_stage.sv
hw/rtl/b2da_lead.sv
hw/rtl/b2da_serial.sv
hw/rtl/binary_to_decimal_ascii.sv
test/tb_top.sv
